// ===== hdl/lwt_pkg.sv =====
// lwt_pkg: shared sizes, codes and record types of the reader-writer lock word table
// no dependencies; imported by every module of the block but lwt_ram
`default_nettype none

package lwt_pkg;

    // table geometry
    localparam int NUM_LOCKS      = 64;
    localparam int MAX_READERS    = 256;
    localparam int THREAD_ID_BITS = 16;

    localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int LVL_W   = $clog2(2 * MAX_READERS) + 1;

    // fixed field widths of the request and result transfers
    localparam int OP_W     = 3;
    localparam int IDX_W    = 6;
    localparam int TID_IN_W = 16;
    localparam int CNT_W    = 9;

    typedef logic signed [LVL_W-1:0] level_t;

    // lock word landmarks: free, second exclusive hold, recursion ceiling
    localparam level_t LVL_FREE  = level_t'(MAX_READERS);
    localparam level_t LVL_FLOOR = level_t'(-MAX_READERS);
    localparam level_t LVL_OVF   = level_t'(1 - 2 * MAX_READERS);
    localparam level_t LVL_ZERO  = level_t'(0);
    localparam level_t LVL_ONE   = level_t'(1);
    localparam level_t LVL_TWO   = level_t'(2);

    typedef enum logic [OP_W-1:0] {
        OP_S_TRY      = 3'd0,
        OP_X_LOCK     = 3'd1,
        OP_X_NOWAIT   = 3'd2,
        OP_S_UNLOCK   = 3'd3,
        OP_X_UNLOCK   = 3'd4,
        OP_SET_WAITER = 3'd5,
        OP_QUERY      = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_GRANT   = 2'd0,
        ST_RESERVE = 2'd1,
        ST_DENY    = 2'd2,
        ST_ERROR   = 2'd3
    } grant_code_t;

    typedef enum logic [1:0] {
        WS_FREE = 2'd0,
        WS_EXCL = 2'd1,
        WS_WAIT = 2'd2
    } wstate_t;

    // one lock word record as held in the table memory
    typedef struct packed {
        logic                      waiter;
        logic                      rec;
        logic [THREAD_ID_BITS-1:0] owner;
        level_t                    level;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        waiter: 1'b0,
        rec:    1'b0,
        owner:  '0,
        level:  LVL_FREE
    };

    // decoded request
    typedef struct packed {
        opcode_t             op;
        logic [IDX_W-1:0]    idx;
        logic [TID_IN_W-1:0] tid;
        logic                pass;
    } req_t;

    // result fields
    typedef struct packed {
        grant_code_t      status;
        logic             wake_all;
        logic             wake_res;
        wstate_t          ws;
        logic [CNT_W-1:0] rc;
        logic [CNT_W-1:0] xc;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/lwt_ram.sv =====
// lwt_ram: generic single-write, single-read synchronous memory, registered read data
// no dependencies
`default_nettype none

module lwt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lwt_update.sv =====
// lwt_update: applies one request to a lock word record and forms the result fields
// depends on lwt_pkg
`default_nettype none

module lwt_update (
    input  wire lwt_pkg::req_t   req,
    input  wire logic            in_range,
    input  wire lwt_pkg::entry_t cur,
    output lwt_pkg::entry_t      nxt,
    output lwt_pkg::result_t     res
);
    import lwt_pkg::*;

    level_t                    lw;
    level_t                    nl;
    level_t                    relock_lvl;
    logic                      relock_err;
    logic                      owner_ok;
    logic [THREAD_ID_BITS-1:0] tid_m;
    entry_t                    upd;
    grant_code_t               st;
    logic                      wake_all;
    logic                      wake_res;

    assign lw       = cur.level;
    assign tid_m    = req.tid[THREAD_ID_BITS-1:0];
    assign owner_ok = cur.rec && (cur.owner == tid_m);

    // recursive relock by the owning writer
    assign relock_err = (lw != LVL_ZERO) && ((lw > LVL_FLOOR) || (lw <= LVL_OVF));
    assign relock_lvl = (lw == LVL_ZERO) ? LVL_FLOOR : lw - LVL_ONE;

    // opcode decode and record update
    always_comb begin
        upd      = cur;
        st       = ST_GRANT;
        wake_all = 1'b0;
        wake_res = 1'b0;
        unique case (req.op)
            OP_S_TRY: begin
                if (lw > LVL_ONE) begin
                    upd.level = lw - LVL_ONE;
                end else begin
                    st = ST_DENY;
                end
            end
            OP_X_LOCK: begin
                if (lw > LVL_ZERO) begin
                    upd.level = lw - LVL_FREE;
                    upd.owner = tid_m;
                    upd.rec   = !req.pass;
                    st        = (lw == LVL_FREE) ? ST_GRANT : ST_RESERVE;
                end else if (!req.pass && owner_ok) begin
                    if (relock_err) begin
                        st = ST_ERROR;
                    end else begin
                        upd.level = relock_lvl;
                    end
                end else begin
                    st = ST_DENY;
                end
            end
            OP_X_NOWAIT: begin
                if (lw == LVL_FREE) begin
                    upd.level = LVL_ZERO;
                    upd.owner = tid_m;
                    upd.rec   = 1'b1;
                end else if ((lw <= LVL_ZERO) && owner_ok) begin
                    if (relock_err) begin
                        st = ST_ERROR;
                    end else begin
                        upd.level = relock_lvl;
                    end
                end else begin
                    st = ST_DENY;
                end
            end
            OP_S_UNLOCK: begin
                if (((lw > LVL_ZERO) && (lw < LVL_FREE)) ||
                    ((lw < LVL_ZERO) && (lw > LVL_FLOOR))) begin
                    upd.level = lw + LVL_ONE;
                    wake_res  = (lw == -LVL_ONE);
                end else begin
                    st = ST_ERROR;
                end
            end
            OP_X_UNLOCK: begin
                if (!((lw == LVL_ZERO) || (lw <= LVL_FLOOR)) ||
                    (cur.rec && (cur.owner != tid_m))) begin
                    st = ST_ERROR;
                end else if (lw == LVL_ZERO) begin
                    upd.rec   = 1'b0;
                    upd.level = LVL_FREE;
                    if (cur.waiter) begin
                        upd.waiter = 1'b0;
                        wake_all   = 1'b1;
                    end
                end else if (lw == LVL_FLOOR) begin
                    upd.level = LVL_ZERO;
                end else begin
                    upd.level = lw + LVL_ONE;
                end
            end
            OP_SET_WAITER: begin
                upd.waiter = 1'b1;
            end
            OP_QUERY: begin
            end
            default: begin
                st = ST_ERROR;
            end
        endcase
    end

    assign nxt = in_range ? upd : cur;
    assign nl  = upd.level;

    // result fields from the lock word after the step
    always_comb begin
        res          = '0;
        res.status   = st;
        res.wake_all = wake_all;
        res.wake_res = wake_res;
        if (nl > LVL_ZERO) begin
            res.ws = WS_FREE;
            res.rc = CNT_W'(LVL_FREE - nl);
        end else if ((nl == LVL_ZERO) || (nl <= LVL_FLOOR)) begin
            res.ws = WS_EXCL;
            res.xc = (nl == LVL_ZERO) ? CNT_W'(1) : CNT_W'(LVL_TWO - (nl + LVL_FREE));
        end else begin
            res.ws = WS_WAIT;
            res.rc = CNT_W'(-nl);
        end
        if (!in_range) begin
            res        = '0;
            res.status = ST_ERROR;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rw_lock_word_table.sv =====
// rw_lock_word_table: top level, stream ports, table memory, forwarding and output register
// depends on lwt_pkg, lwt_ram and lwt_update
`default_nettype none

// Reader-writer lock word table. Each request transfer names a lock, a thread, a pass flag
// and an opcode; each one yields exactly one result transfer. A new request is accepted every
// cycle while the result side keeps taking transfers: the accept cycle reads the lock record
// from the table memory, then the update stage applies the request, writes the record back
// and loads the output register, which offers the result. A stalled result holds the update
// stage and, behind it, the input. The rate is set by the single read-modify-write on the
// table memory; a request that follows right behind one to the same lock takes the record
// from the write-back register. Per-lock valid bits stand for the reset state, so every lock
// reads as free right out of reset with no clearing pass.

module rw_lock_word_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[2:0], lock_index[8:3], thread[24:9], pass_flag[25], zero[31:26]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], wake_all_waiters[2], wake_reserved_writer[3], writer_state[5:4],
    // reader_count[14:6], exclusive_count[23:15]
    output logic      [23:0] m_tdata
);
    import lwt_pkg::*;

    req_t               s_req;
    logic [LOCK_AW-1:0] s_addr;
    logic               s_fire;

    logic               s1_vld_reg;
    logic               s1_vld_next;
    req_t               s1_req_reg;
    logic [LOCK_AW-1:0] s1_addr;
    logic               s1_in_range;
    logic               s1_fire;

    logic [NUM_LOCKS-1:0] valid_reg;
    logic                 rd_vld_reg;
    logic [ENTRY_W-1:0]   rd_data;

    logic               wr_en;
    logic               wr_vld_reg;
    logic [LOCK_AW-1:0] wr_addr_reg;
    entry_t             wr_data_reg;
    logic               fwd_hit;

    entry_t             cur_entry;
    entry_t             upd_next;
    result_t            upd_res;

    logic               out_vld_reg;
    logic               out_vld_next;
    logic [23:0]        out_data_reg;

    // request unpacking
    assign s_req.op   = opcode_t'(s_tdata[2:0]);
    assign s_req.idx  = s_tdata[8:3];
    assign s_req.tid  = s_tdata[24:9];
    assign s_req.pass = s_tdata[25];
    assign s_addr     = LOCK_AW'(s_req.idx);

    // pipeline handshake
    assign s1_fire  = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    assign s1_addr     = LOCK_AW'(s1_req_reg.idx);
    assign s1_in_range = (int'(s1_req_reg.idx) < NUM_LOCKS);
    assign wr_en       = s1_fire && s1_in_range;

    assign s1_vld_next  = s_fire || (s1_vld_reg && !s1_fire);
    assign out_vld_next = s1_fire || (out_vld_reg && !m_tready);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            valid_reg   <= '0;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (s1_fire) begin
                wr_vld_reg <= wr_en;
            end
            if (wr_en) begin
                valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // request, valid bit, write-back payload and output data registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_req_reg <= s_req;
            rd_vld_reg <= valid_reg[s_addr];
        end
        if (wr_en) begin
            wr_addr_reg <= s1_addr;
            wr_data_reg <= upd_next;
        end
        if (s1_fire) begin
            out_data_reg <= {upd_res.xc, upd_res.rc, upd_res.ws, upd_res.wake_res,
                             upd_res.wake_all, upd_res.status};
        end
    end

    // lock record storage
    lwt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (NUM_LOCKS),
        .ADDR_W (LOCK_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (upd_next),
        .rd_en   (s_fire),
        .rd_addr (s_addr),
        .rd_data (rd_data)
    );

    // forward the last write-back over a stale read of the same lock
    assign fwd_hit   = wr_vld_reg && (wr_addr_reg == s1_addr);
    assign cur_entry = fwd_hit    ? wr_data_reg :
                       rd_vld_reg ? entry_t'(rd_data) : ENTRY_RESET;

    lwt_update u_update (
        .req      (s1_req_reg),
        .in_range (s1_in_range),
        .cur      (cur_entry),
        .nxt      (upd_next),
        .res      (upd_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // an error result leaves the lock record untouched
    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && (upd_res.status == ST_ERROR)) |-> (upd_next == cur_entry))
        else $error("error result modified the lock record");

    // written lock words stay within the legal level range
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((upd_next.level <= LVL_FREE) && (upd_next.level >= LVL_OVF)))
        else $error("lock level out of range on write-back");

    // a written lock is marked valid from the next cycle on
    a_valid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> valid_reg[$past(s1_addr)])
        else $error("valid bit not set after write-back");

    // input stalls only while a request is held in the update stage
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled without a blocked request");
`endif

endmodule

`default_nettype wire

// ===== test/lwt_lock_checker.sv =====
// lwt_lock_checker: watches both streams of rw_lock_word_table, keeps its own lock word table,
// predicts every result transfer and compares it field by field
// depends on lwt_pkg
`default_nettype none

module lwt_lock_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // opcode[2:0], lock_index[8:3], thread[24:9], pass_flag[25], zero[31:26]
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], wake_all_waiters[2], wake_reserved_writer[3], writer_state[5:4],
    // reader_count[14:6], exclusive_count[23:15]
    input  wire logic [23:0] m_tdata,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lwt_pkg::*;

    localparam int FULL = MAX_READERS;

    // shadow lock words
    int                        word_level     [NUM_LOCKS];
    logic [THREAD_ID_BITS-1:0] word_owner     [NUM_LOCKS];
    logic                      word_recursive [NUM_LOCKS];
    logic                      word_waiter    [NUM_LOCKS];

    // results owed by the block, oldest first
    result_t lock_outcomes [$];

    // one more exclusive hold by the owning writer
    function automatic grant_code_t deepen_hold(input int idx);
        int lw;
        lw = word_level[idx];
        if (lw == 0) begin
            word_level[idx] = -FULL;
            return ST_GRANT;
        end
        // reservation still pending, or recursion ceiling reached
        if (lw > -FULL || lw - 1 <= -2 * FULL)
            return ST_ERROR;
        word_level[idx] = lw - 1;
        return ST_GRANT;
    endfunction

    // apply one request to the shadow table and work out its result
    function automatic result_t apply_lock_request(input logic [OP_W-1:0] op, input int idx,
                                                   input logic [THREAD_ID_BITS-1:0] tid,
                                                   input logic pass);
        result_t r;
        int      lw;
        logic    owner_ok;
        r = '0;
        r.status = ST_GRANT;
        lw = word_level[idx];
        owner_ok = word_recursive[idx] && (word_owner[idx] == tid);
        case (op)
            OP_S_TRY: begin
                if (lw > 1)
                    word_level[idx] = lw - 1;
                else
                    r.status = ST_DENY;
            end
            OP_X_LOCK: begin
                if (lw > 0) begin
                    word_level[idx] = lw - FULL;
                    word_owner[idx] = tid;
                    word_recursive[idx] = !pass;
                    r.status = (lw == FULL) ? ST_GRANT : ST_RESERVE;
                end else if (!pass && owner_ok) begin
                    r.status = deepen_hold(idx);
                end else begin
                    r.status = ST_DENY;
                end
            end
            OP_X_NOWAIT: begin
                if (lw == FULL) begin
                    word_level[idx] = 0;
                    word_owner[idx] = tid;
                    word_recursive[idx] = 1'b1;
                end else if (lw <= 0 && owner_ok) begin
                    r.status = deepen_hold(idx);
                end else begin
                    r.status = ST_DENY;
                end
            end
            OP_S_UNLOCK: begin
                if ((lw > 0 && lw < FULL) || (lw < 0 && lw > -FULL)) begin
                    word_level[idx] = lw + 1;
                    r.wake_res = (lw + 1 == 0);
                end else begin
                    r.status = ST_ERROR;
                end
            end
            OP_X_UNLOCK: begin
                if (!(lw == 0 || lw <= -FULL) ||
                    (word_recursive[idx] && word_owner[idx] != tid)) begin
                    r.status = ST_ERROR;
                end else if (lw == 0) begin
                    // last exclusive hold goes away
                    word_recursive[idx] = 1'b0;
                    word_level[idx] = FULL;
                    if (word_waiter[idx]) begin
                        word_waiter[idx] = 1'b0;
                        r.wake_all = 1'b1;
                    end
                end else if (lw == -FULL) begin
                    word_level[idx] = 0;
                end else begin
                    word_level[idx] = lw + 1;
                end
            end
            OP_SET_WAITER: begin
                word_waiter[idx] = 1'b1;
            end
            OP_QUERY: begin
            end
            default: begin
                r.status = ST_ERROR;
            end
        endcase

        // report the lock word as it stands now
        lw = word_level[idx];
        if (lw > 0) begin
            r.ws = WS_FREE;
            r.rc = CNT_W'(FULL - lw);
        end else if (lw == 0 || lw <= -FULL) begin
            r.ws = WS_EXCL;
            r.xc = (lw == 0) ? CNT_W'(1) : CNT_W'(2 - (lw + FULL));
        end else begin
            r.ws = WS_WAIT;
            r.rc = CNT_W'(-lw);
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LOCKS; i++) begin
                word_level[i] = FULL;
                word_owner[i] = '0;
                word_recursive[i] = 1'b0;
                word_waiter[i] = 1'b0;
            end
            lock_outcomes.delete();
            fail_count = 0;
        end else begin
            // result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (lock_outcomes.size() == 0) begin
                    $error("result transfer with nothing outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = lock_outcomes.pop_front();
                    compare_field("status", want.status, m_tdata[1:0]);
                    compare_field("wake_all_waiters", want.wake_all, m_tdata[2]);
                    compare_field("wake_reserved_writer", want.wake_res, m_tdata[3]);
                    compare_field("writer_state", want.ws, m_tdata[5:4]);
                    compare_field("reader_count", want.rc, m_tdata[14:6]);
                    compare_field("exclusive_count", want.xc, m_tdata[23:15]);
                end
            end
            // request transfer
            if (s_tvalid && s_tready)
                lock_outcomes.push_back(apply_lock_request(s_tdata[2:0], int'(s_tdata[8:3]),
                                                           s_tdata[24:9], s_tdata[25]));
        end
        outstanding = lock_outcomes.size();
    end

endmodule

`default_nettype wire

// ===== test/rw_lock_word_table_test.sv =====
// rw_lock_word_table_test: stimulus for the lock word table, directed cases, lock sessions
// and noise under bursty requests and a stalling receiver; checking is in lwt_lock_checker
// depends on lwt_pkg, rw_lock_word_table and lwt_lock_checker
`default_nettype none

module rw_lock_word_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lwt_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEM_COUNT      = 1250;
    localparam int HOLD_OFF_AFTER  = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WORK_LOCKS      = 8;
    localparam int READER_LOCK     = 62;
    localparam int RECURSION_LOCK  = 63;

    // opcode value the block does not define
    localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    rw_lock_word_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lwt_lock_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rw_lock_word_table");
            $finish;
        end
    end

    // result side: ready in phases of random length and duty, plus one long hold-off
    initial begin
        int phase_len;
        int ready_pct;
        bit hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (!hold_done && items_sent >= HOLD_OFF_AFTER) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                phase_len = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                repeat (phase_len) begin
                    @(negedge aclk);
                    m_tready <= ($urandom_range(0, 99) < ready_pct);
                end
            end
        end
    end

    function automatic logic [15:0] rand_tid();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // one request transfer, in bursts with random gaps in between
    task automatic send_request(input logic [OP_W-1:0] op, input int idx,
                                input logic [15:0] tid, input logic pass);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pass, tid, idx[IDX_W-1:0], op};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // readers come and go on one lock
    task automatic shared_session();
        int lock_id;
        int readers;
        lock_id = $urandom_range(0, WORK_LOCKS - 1);
        readers = $urandom_range(1, 4);
        repeat (readers) send_request(OP_S_TRY, lock_id, rand_tid(), rand_bit());
        if ($urandom_range(0, 1))
            send_request(OP_QUERY, lock_id, rand_tid(), rand_bit());
        repeat (readers) send_request(OP_S_UNLOCK, lock_id, rand_tid(), rand_bit());
    endtask

    // writer takes a lock, relocks a few times, then releases every hold
    task automatic exclusive_session();
        int              lock_id;
        int              depth;
        logic [15:0]     owner;
        logic            pass;
        logic [OP_W-1:0] first_op;
        lock_id  = $urandom_range(0, WORK_LOCKS - 1);
        owner    = rand_tid();
        pass     = rand_bit();
        depth    = $urandom_range(0, 3);
        first_op = $urandom_range(0, 1) ? OP_X_LOCK : OP_X_NOWAIT;
        if ($urandom_range(0, 2) == 0)
            send_request(OP_SET_WAITER, lock_id, rand_tid(), rand_bit());
        send_request(first_op, lock_id, owner, pass);
        repeat (depth)
            send_request($urandom_range(0, 1) ? OP_X_LOCK : OP_X_NOWAIT, lock_id, owner, 1'b0);
        // a competing thread tries its luck
        if ($urandom_range(0, 3) == 0)
            send_request($urandom_range(0, 1) ? OP_X_LOCK : OP_X_UNLOCK, lock_id, rand_tid(),
                         rand_bit());
        repeat (depth + 1)
            send_request(OP_X_UNLOCK, lock_id,
                         (pass && $urandom_range(0, 1)) ? rand_tid() : owner, 1'b0);
    endtask

    // writer reserves a read-held lock and gets it when the readers drain
    task automatic reservation_session();
        int          lock_id;
        int          readers;
        logic [15:0] writer;
        lock_id = $urandom_range(0, WORK_LOCKS - 1);
        readers = $urandom_range(1, 3);
        writer  = rand_tid();
        repeat (readers) send_request(OP_S_TRY, lock_id, rand_tid(), rand_bit());
        send_request(OP_X_LOCK, lock_id, writer, rand_bit());
        if ($urandom_range(0, 1))
            send_request(OP_S_TRY, lock_id, rand_tid(), rand_bit());
        repeat (readers) send_request(OP_S_UNLOCK, lock_id, rand_tid(), rand_bit());
        send_request(OP_X_UNLOCK, lock_id, writer, 1'b0);
    endtask

    // fill a lock up to the reader limit, then reserve it with all readers still in
    task automatic fill_readers(input int lock_id);
        logic [15:0] writer;
        writer = rand_tid();
        repeat (MAX_READERS + 1)
            send_request(OP_S_TRY, lock_id, rand_tid(), rand_bit());
        send_request(OP_X_LOCK, lock_id, writer, 1'b0);
        send_request(OP_X_LOCK, lock_id, writer, 1'b0);
        send_request(OP_S_TRY, lock_id, rand_tid(), rand_bit());
    endtask

    // relock one writer up to the recursion ceiling and past it
    task automatic fill_recursion(input int lock_id);
        logic [15:0] owner;
        owner = rand_tid();
        send_request(OP_X_NOWAIT, lock_id, owner, rand_bit());
        repeat (MAX_READERS + 2)
            send_request($urandom_range(0, 1) ? OP_X_LOCK : OP_X_NOWAIT, lock_id, owner, 1'b0);
        send_request(OP_X_UNLOCK, lock_id, owner, 1'b0);
    endtask

    // main stimulus and verdict
    initial begin
        int pick;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // free lock: query and unlocks without a hold
        send_request(OP_QUERY, 0, 16'h0000, 1'b0);
        send_request(OP_S_UNLOCK, 0, 16'h0000, 1'b0);
        send_request(OP_X_UNLOCK, 0, 16'h0000, 1'b0);
        // reservation, relock while reserved, drain by the last reader
        send_request(OP_S_TRY, 0, 16'hFFFF, 1'b1);
        send_request(OP_X_LOCK, 0, 16'h1234, 1'b0);
        send_request(OP_X_LOCK, 0, 16'h1234, 1'b0);
        send_request(OP_S_UNLOCK, 0, 16'hFFFF, 1'b0);
        // no-wait relock, foreign unlock, waiter flag and the wake on last unlock
        send_request(OP_X_NOWAIT, 0, 16'h1234, 1'b1);
        send_request(OP_X_UNLOCK, 0, 16'h4321, 1'b0);
        send_request(OP_SET_WAITER, 0, 16'h4321, 1'b0);
        send_request(OP_X_UNLOCK, 0, 16'h1234, 1'b0);
        send_request(OP_X_UNLOCK, 0, 16'h1234, 1'b0);
        // pass flag blocks recursion, shared try on a write-held lock
        send_request(OP_X_NOWAIT, 1, 16'hAAAA, 1'b1);
        send_request(OP_X_LOCK, 1, 16'hAAAA, 1'b1);
        send_request(OP_S_TRY, 1, 16'h5555, 1'b0);
        send_request(OP_X_UNLOCK, 1, 16'hAAAA, 1'b0);
        // passable lock released by another thread
        send_request(OP_X_LOCK, 2, 16'h5555, 1'b1);
        send_request(OP_X_LOCK, 2, 16'h5555, 1'b0);
        send_request(OP_X_UNLOCK, 2, 16'h0001, 1'b0);
        // busy lock, undefined opcode, no-wait relock while reserved
        send_request(OP_S_TRY, 3, 16'h00FF, 1'b0);
        send_request(OP_X_NOWAIT, 3, 16'hF0F0, 1'b0);
        send_request(OP_X_LOCK, 3, 16'h0F0F, 1'b0);
        send_request(OP_X_NOWAIT, 3, 16'h0F0F, 1'b0);
        send_request(OP_UNDEFINED, 3, 16'hFFFF, 1'b1);
        send_request(OP_S_UNLOCK, 3, 16'h00FF, 1'b0);
        send_request(OP_X_UNLOCK, 3, 16'h0F0F, 1'b0);

        // reader limit and recursion ceiling on locks of their own
        fill_readers(READER_LOCK);
        fill_recursion(RECURSION_LOCK);

        // mixed lock sessions with some noise
        while (items_sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                shared_session();
            else if (pick < 55)
                exclusive_session();
            else if (pick < 75)
                reservation_session();
            else
                send_request(OP_W'($urandom_range(0, 7)), $urandom_range(0, NUM_LOCKS - 1),
                             rand_tid(), rand_bit());
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // let the last results come out
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS rw_lock_word_table");
        else
            $display("FAIL rw_lock_word_table");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/lwt_pkg.sv
hdl/lwt_ram.sv
hdl/lwt_update.sv
hdl/rw_lock_word_table.sv
test/lwt_lock_checker.sv
test/rw_lock_word_table_test.sv
